// File: hw/rtl/pdht_pkg.sv
// Package for the point de-duplication hash table.
// Widths, depths and hash constants; used by point_dedup_hash_table_unit and pdht_checker.
package pdht_pkg;
    localparam int BUCKETS     = 1024;
    localparam int NODES       = 4096;
    localparam int COORD_W     = 24;
    localparam int ID_W        = 13;
    localparam int CNT_W       = 11;
    localparam int BKT_AW      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int NODE_AW     = $clog2(NODES);
    localparam int NODE_W      = 2 * COORD_W + ID_W;
    localparam logic [31:0] GOLDEN_FRAC = 32'h9E3779B9;
    localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(1024);
    localparam logic [ID_W-1:0] NODES_ID = ID_W'(NODES);
    localparam logic [0:0] REG_BUCKET_COUNT = 1'b0;
endpackage

// File: hw/rtl/pdht_ram.sv
// Generic single-port-write, single-read synchronous RAM, registered read.
// No dependencies.
module pdht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: hw/rtl/point_dedup_hash_table_unit.sv
// Top level of the point de-duplication hash table.
// Uses pdht_pkg and pdht_ram (bucket heads and node pool).
//
// One point at a time. After reset a clearing pass zeroes every entry of the bucket-head
// memory; no point is taken until it ends. After a point is accepted, hashing runs
// through the key, two multiplies and the bucket-head read, then each chain node
// visited takes a node memory read, then a compare. A hit ends the walk with the
// node's id; a miss ends with an end-of-chain check and then the insert write. The
// result holds in the output register until it is taken, and the block then returns
// to idle before it takes the next point.
// The chain walk through the single-read node memory sets the rate.
module point_dedup_hash_table_unit
    import pdht_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [COORD_W-1:0] i_x_coord,
    input  logic [COORD_W-1:0] i_y_coord,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [ID_W-1:0]    o_node_id,
    output logic               o_created,
    output logic               o_table_full,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_KEY, S_MUL1, S_MUL2, S_HEAD, S_NREQ, S_NCMP,
        S_DONE, S_OUT
    } t_state;

    t_state              r_state;
    logic [CNT_W-1:0]    r_bcount;
    logic [BKT_AW-1:0]   r_clr;
    logic [COORD_W-1:0]  r_x, r_y;
    logic [31:0]         r_key, r_frac;
    logic [BKT_AW-1:0]   r_bkt;
    logic [ID_W-1:0]     r_head, r_id, r_count;
    logic [ID_W-1:0]     r_steps;
    logic [ID_W-1:0]     r_oid;
    logic                r_ocr, r_ofull;

    // Config port
    assign pready = 1'b1;
    assign prdata = {21'd0, r_bcount};
    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_BUCKET_COUNT);

    // Hash datapath
    logic [COORD_W:0] sum;
    logic [31:0]      key;
    assign sum = {1'b0, r_x} + {1'b0, r_y};
    // s*(s+1)/2 mod 2^32: one of s, s+1 is even; halve it first
    logic [31:0] sa, sb;
    always_comb begin
        if (sum[0]) begin
            sa = 32'(sum);
            sb = 32'((({7'd0, sum} + 32'd1) >> 1));
        end else begin
            sa = 32'(sum >> 1);
            sb = 32'({7'd0, sum} + 32'd1);
        end
    end
    assign key = 32'(sa * sb) + {8'd0, r_y};

    logic [CNT_W-1:0] m_eff;
    always_comb begin
        if (r_bcount == '0) m_eff = CNT_W'(1);
        else if ({21'd0, r_bcount} > 32'(BUCKETS)) m_eff = CNT_W'(BUCKETS);
        else m_eff = r_bcount;
    end
    logic [31:0] frac;
    logic [CNT_W+31:0] bprod;
    logic [CNT_W-1:0]  braw;
    assign frac  = 32'(r_key * GOLDEN_FRAC);
    assign bprod = {{CNT_W{1'b0}}, r_frac} * {32'd0, m_eff};
    assign braw  = bprod[CNT_W+31:32];

    // Memories
    logic              head_we;
    logic [BKT_AW-1:0] head_waddr;
    logic [ID_W-1:0]   head_wdata, head_rdata;
    logic              node_we;
    logic [NODE_W-1:0] node_rdata;
    logic [NODE_AW-1:0] node_raddr;
    logic [ID_W-1:0]   cur_id;

    // first chain step reads the node named by the bucket head
    assign cur_id     = (r_state == S_NREQ && r_steps == '0) ? head_rdata : r_id;
    assign head_we    = (r_state == S_CLEAR) || (r_state == S_DONE && r_count < NODES_ID);
    assign head_waddr = (r_state == S_CLEAR) ? r_clr : r_bkt;
    assign head_wdata = (r_state == S_CLEAR) ? '0 : ID_W'(r_count + 1'b1);
    assign node_we    = (r_state == S_DONE) && (r_count < NODES_ID);
    assign node_raddr = NODE_AW'(cur_id - 1'b1);

    pdht_ram #(.WIDTH(ID_W), .DEPTH(BUCKETS)) u_head (
        .i_clk(i_clk), .i_we(head_we), .i_waddr(head_waddr), .i_wdata(head_wdata),
        .i_raddr(r_bkt), .o_rdata(head_rdata)
    );
    pdht_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_node (
        .i_clk(i_clk), .i_we(node_we), .i_waddr(NODE_AW'(r_count)),
        .i_wdata({r_x, r_y, r_head}), .i_raddr(node_raddr), .o_rdata(node_rdata)
    );

    logic hit;
    assign hit = (node_rdata[NODE_W-1 -: COORD_W] == r_x) &&
                 (node_rdata[ID_W +: COORD_W] == r_y);

    assign o_ready      = (r_state == S_IDLE);
    assign o_valid      = (r_state == S_OUT);
    assign o_node_id    = r_oid;
    assign o_created    = r_ocr;
    assign o_table_full = r_ofull;

    // Control sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_bcount <= CNT_RESET;
            r_count  <= '0;
        end else begin
            if (cfg_wr) r_bcount <= pwdata[CNT_W-1:0];
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= BKT_AW'(r_clr + 1'b1);
                    if (r_clr == BKT_AW'(BUCKETS - 1)) r_state <= S_IDLE;
                end
                S_IDLE: if (i_valid) begin
                    r_x <= i_x_coord;
                    r_y <= i_y_coord;
                    r_state <= S_KEY;
                end
                S_KEY: begin
                    r_key <= key;
                    r_state <= S_MUL1;
                end
                S_MUL1: begin
                    r_frac <= frac;
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_bkt <= (32'(braw) >= 32'(BUCKETS)) ? BKT_AW'(BUCKETS - 1)
                                                         : BKT_AW'(braw);
                    r_state <= S_HEAD;
                end
                S_HEAD: r_state <= S_NREQ; // head read in flight
                S_NREQ: begin
                    if (r_state == S_NREQ && r_steps == '0) begin
                        r_head <= head_rdata;
                        r_id   <= head_rdata;
                    end
                    r_state <= S_NCMP;
                    if ((r_steps == '0 ? head_rdata : r_id) == '0 ||
                        (r_steps == '0 ? head_rdata : r_id) > NODES_ID ||
                        r_steps == NODES_ID) r_state <= S_DONE;
                end
                S_NCMP: begin
                    if (hit) begin
                        r_oid <= r_id; r_ocr <= 1'b0; r_ofull <= 1'b0;
                        r_state <= S_OUT;
                    end else begin
                        r_id    <= node_rdata[ID_W-1:0];
                        r_steps <= ID_W'(r_steps + 1'b1);
                        r_state <= S_NREQ;
                    end
                end
                S_DONE: begin
                    if (r_count < NODES_ID) begin
                        r_oid   <= ID_W'(r_count + 1'b1);
                        r_ocr   <= 1'b1; r_ofull <= 1'b0;
                        r_count <= ID_W'(r_count + 1'b1);
                    end else begin
                        r_oid <= '0; r_ocr <= 1'b0; r_ofull <= 1'b1;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: if (i_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
            if (r_state == S_MUL2) r_steps <= '0;
        end
    end
    // r_steps cleared in S_MUL2 so S_NREQ first pass uses head data
endmodule

// File: hw/rtl/pdht_checker.sv
// Port-level assertions for the point de-duplication hash table.
// Uses pdht_pkg; bound to point_dedup_hash_table_unit.
module pdht_checker
    import pdht_pkg::*;
(
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_valid,
    input logic            o_ready,
    input logic            o_valid,
    input logic            i_ready,
    input logic [ID_W-1:0] o_node_id,
    input logic            o_created,
    input logic            o_table_full
);
    // a result never claims both insert and full
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_created && o_table_full)) else $error("created and full");
    // full results carry id zero, others a nonzero id
    a_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_table_full == (o_node_id == '0))) else $error("bad id");
    // no new transaction while a result waits
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("overlap");
    // result stays while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_node_id)) else $error("drop");
    // an accepted transaction makes the block busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready) else $error("not busy");
endmodule

bind point_dedup_hash_table_unit pdht_checker u_pdht_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_node_id(o_node_id),
    .o_created(o_created), .o_table_full(o_table_full)
);
